// File: design/assert_macros.svh
// Assertion helpers for the supply failover design.
// Concurrent checks are compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Condition a implies condition b in the same cycle.
`define RSF_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
// Condition a implies condition b in the next cycle.
`define RSF_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define RSF_ASSERT_IMP(label, clk, rst, a, b)
`define RSF_ASSERT_NEXT(label, clk, rst, a, b)
`endif

`endif

// File: design/rsf_pkg.sv
package rsf_pkg;

   // Field widths
   localparam int TimeW  = 32;
   localparam int CodeW  = 12;
   localparam int MvW    = 16;
   localparam int MaW    = 16;
   localparam int CountW = 8;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 32;

   // Register indexes
   localparam logic [CsrIdxW-1:0] REG_SUPPLY_OK_CODE      = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_BUS_OK_MV           = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_CURRENT_MAX_MA      = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_CURRENT_OVERLOAD_MA = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_MAX_SWITCHES        = 3'd4;
   localparam logic [CsrIdxW-1:0] REG_OVERLOAD_TIMEOUT_MS = 3'd5;
   localparam logic [CsrIdxW-1:0] REG_SWITCH_WINDOW_MS    = 3'd6;
   localparam logic [CsrIdxW-1:0] REG_RESET_TIME_MS       = 3'd7;

   // Register reset values
   localparam logic [CodeW-1:0]  RST_SUPPLY_OK_CODE      = 12'd2048;
   localparam logic [MvW-1:0]    RST_BUS_OK_MV           = 16'd20000;
   localparam logic [MaW-1:0]    RST_CURRENT_MAX_MA      = 16'd640;
   localparam logic [MaW-1:0]    RST_CURRENT_OVERLOAD_MA = 16'd1000;
   localparam logic [CountW-1:0] RST_MAX_SWITCHES        = 8'd3;
   localparam logic [TimeW-1:0]  RST_OVERLOAD_TIMEOUT_MS = 32'd5000;
   localparam logic [TimeW-1:0]  RST_SWITCH_WINDOW_MS    = 32'd1000;
   localparam logic [TimeW-1:0]  RST_RESET_TIME_MS       = 32'd10000;

   localparam logic [CountW-1:0] COUNT_MAX = 8'd255;

   // Which supply is switched on
   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_ONE  = 2'd1,
      ACT_TWO  = 2'd2
   } active_type;

   // One registered sample
   typedef struct packed {
      logic [TimeW-1:0]  now_ms;
      logic [CodeW-1:0]  supply1_code;
      logic [CodeW-1:0]  supply2_code;
      logic [MvW-1:0]    bus_mv;
      logic [MaW-1:0]    bus_ma;
      logic [MaW-1:0]    aux_ma;
      logic              reset_button;
   } sample_type;

   // One result
   typedef struct packed {
      logic       supply1_drive;
      logic       supply2_drive;
      active_type active_supply;
      logic       supply1_ok;
      logic       supply2_ok;
      logic       supply1_changed;
      logic       supply2_changed;
      logic       bus_good;
      logic       current_good;
      logic       reset_busy;
      logic       save_request;
      logic       shutdown_event;
   } result_type;

   // Modular elapsed time strictly longer than a duration
   function automatic logic elapsed_over(input logic [TimeW-1:0] now,
                                         input logic [TimeW-1:0] start,
                                         input logic [TimeW-1:0] dur);
      logic [TimeW-1:0] diff;
      diff = now - start;
      return diff > dur;
   endfunction

endpackage

// File: design/redundant_supply_failover_top.sv
// A sample accepted into the input register moves on into the result register, which
// drives the result ports, as soon as that register is empty or is being read.
// Throughput: one sample per cycle while the result side does not stall. The input
// register and the result register form a two-entry pipeline, and the failover state
// updates as a sample leaves the input register. The input stalls only while both
// registers are full and the result is stalled. Synchronous active-high reset clears all
// control state and loads the threshold and timing registers with their default values.
module redundant_supply_failover_top
   import rsf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // sample channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [TimeW-1:0]    req_now_ms,
   input  logic [CodeW-1:0]    req_supply1_code,
   input  logic [CodeW-1:0]    req_supply2_code,
   input  logic [MvW-1:0]      req_bus_mv,
   input  logic signed [MaW-1:0] req_bus_ma,
   input  logic signed [MaW-1:0] req_aux_ma,
   input  logic                req_reset_button,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_supply1_drive,
   output logic                rsp_supply2_drive,
   output logic [1:0]          rsp_active_supply,
   output logic                rsp_supply1_ok,
   output logic                rsp_supply2_ok,
   output logic                rsp_supply1_changed,
   output logic                rsp_supply2_changed,
   output logic                rsp_bus_good,
   output logic                rsp_current_good,
   output logic                rsp_reset_busy,
   output logic                rsp_save_request,
   output logic                rsp_shutdown_event,
   // register write port
   input  logic                csr_write_en,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   `include "assert_macros.svh"

   // configuration registers
   logic [CodeW-1:0]  cfg_supply_ok_code_ff;
   logic [MvW-1:0]    cfg_bus_ok_mv_ff;
   logic [MaW-1:0]    cfg_current_max_ma_ff;
   logic [MaW-1:0]    cfg_current_overload_ma_ff;
   logic [CountW-1:0] cfg_max_switches_ff;
   logic [TimeW-1:0]  cfg_overload_timeout_ms_ff;
   logic [TimeW-1:0]  cfg_switch_window_ms_ff;
   logic [TimeW-1:0]  cfg_reset_time_ms_ff;

   // pipeline registers
   logic       in_valid_ff;
   sample_type in_sample_ff;
   logic       out_valid_ff;
   result_type out_result_ff;
   result_type out_result_in;

   // controller state
   logic              ok1_ff, ok2_ff;
   active_type        active_ff, active_in;
   logic              drive1_ff, drive2_ff, drive1_in, drive2_in;
   logic              alarm_noted_ff, alarm_noted_in;
   logic              oc_flag_ff, oc_flag_in;
   logic [TimeW-1:0]  oc_start_ff, oc_start_in;
   logic [CountW-1:0] switch_count_ff, switch_count_in;
   logic [TimeW-1:0]  switch_time_ff, switch_time_in;
   logic              switch_pending_ff, switch_pending_in;
   logic              reset_flag_ff, reset_flag_in;
   logic [TimeW-1:0]  reset_start_ff, reset_start_in;
   logic              reset_armed_ff, reset_armed_in;

   logic advance;
   logic step;

   // handshake: input register moves on whenever the result register frees up
   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_supply_ok_code_ff      <= RST_SUPPLY_OK_CODE;
         cfg_bus_ok_mv_ff           <= RST_BUS_OK_MV;
         cfg_current_max_ma_ff      <= RST_CURRENT_MAX_MA;
         cfg_current_overload_ma_ff <= RST_CURRENT_OVERLOAD_MA;
         cfg_max_switches_ff        <= RST_MAX_SWITCHES;
         cfg_overload_timeout_ms_ff <= RST_OVERLOAD_TIMEOUT_MS;
         cfg_switch_window_ms_ff    <= RST_SWITCH_WINDOW_MS;
         cfg_reset_time_ms_ff       <= RST_RESET_TIME_MS;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_SUPPLY_OK_CODE:      cfg_supply_ok_code_ff      <= csr_wdata[CodeW-1:0];
            REG_BUS_OK_MV:           cfg_bus_ok_mv_ff           <= csr_wdata[MvW-1:0];
            REG_CURRENT_MAX_MA:      cfg_current_max_ma_ff      <= csr_wdata[MaW-1:0];
            REG_CURRENT_OVERLOAD_MA: cfg_current_overload_ma_ff <= csr_wdata[MaW-1:0];
            REG_MAX_SWITCHES:        cfg_max_switches_ff        <= csr_wdata[CountW-1:0];
            REG_OVERLOAD_TIMEOUT_MS: cfg_overload_timeout_ms_ff <= csr_wdata[TimeW-1:0];
            REG_SWITCH_WINDOW_MS:    cfg_switch_window_ms_ff    <= csr_wdata[TimeW-1:0];
            REG_RESET_TIME_MS:       cfg_reset_time_ms_ff       <= csr_wdata[TimeW-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_sample_ff.now_ms       <= req_now_ms;
         in_sample_ff.supply1_code <= req_supply1_code;
         in_sample_ff.supply2_code <= req_supply2_code;
         in_sample_ff.bus_mv       <= req_bus_mv;
         in_sample_ff.bus_ma       <= req_bus_ma;
         in_sample_ff.aux_ma       <= req_aux_ma;
         in_sample_ff.reset_button <= req_reset_button;
      end
   end

   // per-sample decision, in the order: presence, bus reset end, failover,
   // status, overcurrent, window clear, bus reset start
   always_comb begin
      logic n1, n2;
      logic act_fail;
      logic save, shut;
      logic cur_good;
      logic signed [MaW+1:0] total;
      logic signed [MaW+1:0] max_lim;
      logic signed [MaW+1:0] ovl_lim;
      logic [TimeW-1:0] now;

      now      = in_sample_ff.now_ms;
      n1       = in_sample_ff.supply1_code > cfg_supply_ok_code_ff;
      n2       = in_sample_ff.supply2_code > cfg_supply_ok_code_ff;
      total    = {{2{in_sample_ff.bus_ma[MaW-1]}}, in_sample_ff.bus_ma}
               + {{2{in_sample_ff.aux_ma[MaW-1]}}, in_sample_ff.aux_ma};
      max_lim  = {2'b00, cfg_current_max_ma_ff};
      ovl_lim  = {2'b00, cfg_current_overload_ma_ff};
      save     = 1'b0;
      shut     = 1'b0;

      active_in         = active_ff;
      drive1_in         = drive1_ff;
      drive2_in         = drive2_ff;
      alarm_noted_in    = alarm_noted_ff;
      oc_flag_in        = oc_flag_ff;
      oc_start_in       = oc_start_ff;
      switch_count_in   = switch_count_ff;
      switch_time_in    = switch_time_ff;
      switch_pending_in = switch_pending_ff;
      reset_flag_in     = reset_flag_ff;
      reset_start_in    = reset_start_ff;
      reset_armed_in    = reset_armed_ff;

      // finished bus reset
      if (reset_flag_in && elapsed_over(now, reset_start_ff, cfg_reset_time_ms_ff)) begin
         reset_flag_in  = 1'b0;
         reset_armed_in = 1'b0;
      end

      // failover decision
      act_fail = (active_ff == ACT_ONE && !n1) || (active_ff == ACT_TWO && !n2);
      if (!reset_flag_in) begin
         if (switch_count_ff > cfg_max_switches_ff && act_fail) begin
            drive1_in   = 1'b0;
            drive2_in   = 1'b0;
            active_in   = ACT_NONE;
            oc_flag_in  = 1'b1;
            oc_start_in = now;
            shut        = 1'b1;
         end else begin
            case (active_ff)
               ACT_ONE: begin
                  if (!n1) begin
                     if (n2) begin
                        drive1_in         = 1'b0;
                        drive2_in         = 1'b1;
                        active_in         = ACT_TWO;
                        switch_count_in   = (switch_count_ff == COUNT_MAX) ?
                                            switch_count_ff : switch_count_ff + 1'b1;
                        switch_time_in    = now;
                        switch_pending_in = 1'b1;
                        alarm_noted_in    = 1'b0;
                     end else if (!alarm_noted_ff) begin
                        alarm_noted_in = 1'b1;
                        save           = 1'b1;
                     end
                  end
               end
               ACT_TWO: begin
                  if (!n2) begin
                     if (n1) begin
                        drive2_in         = 1'b0;
                        drive1_in         = 1'b1;
                        active_in         = ACT_ONE;
                        switch_count_in   = (switch_count_ff == COUNT_MAX) ?
                                            switch_count_ff : switch_count_ff + 1'b1;
                        switch_time_in    = now;
                        switch_pending_in = 1'b1;
                        alarm_noted_in    = 1'b0;
                     end else if (!alarm_noted_ff) begin
                        alarm_noted_in = 1'b1;
                        save           = 1'b1;
                     end
                  end
               end
               ACT_NONE: begin
                  // restart gated by the shutdown timeout
                  if (!oc_flag_ff ||
                      elapsed_over(now, oc_start_ff, cfg_overload_timeout_ms_ff)) begin
                     if (n1) begin
                        drive2_in      = 1'b0;
                        drive1_in      = 1'b1;
                        active_in      = ACT_ONE;
                        alarm_noted_in = 1'b0;
                     end else if (n2) begin
                        drive1_in      = 1'b0;
                        drive2_in      = 1'b1;
                        active_in      = ACT_TWO;
                        alarm_noted_in = 1'b0;
                     end else begin
                        alarm_noted_in = 1'b1;
                     end
                  end
               end
               default: ;
            endcase
         end
      end

      // current status, taken before a new bus reset can start
      cur_good = reset_flag_in || (total < max_lim);

      // overcurrent shutdown
      if (!reset_flag_in && total > ovl_lim) begin
         drive1_in   = 1'b0;
         drive2_in   = 1'b0;
         active_in   = ACT_NONE;
         oc_flag_in  = 1'b1;
         oc_start_in = now;
         shut        = 1'b1;
      end

      // failover window expiry
      if (switch_pending_in && elapsed_over(now, switch_time_in, cfg_switch_window_ms_ff)) begin
         switch_pending_in = 1'b0;
         switch_count_in   = '0;
      end

      // bus reset start
      if (in_sample_ff.reset_button && !reset_armed_in) begin
         reset_flag_in  = 1'b1;
         reset_armed_in = 1'b1;
         reset_start_in = now;
         drive1_in      = 1'b0;
         drive2_in      = 1'b0;
         active_in      = ACT_NONE;
      end

      out_result_in.supply1_drive   = drive1_in;
      out_result_in.supply2_drive   = drive2_in;
      out_result_in.active_supply   = active_in;
      out_result_in.supply1_ok      = n1;
      out_result_in.supply2_ok      = n2;
      out_result_in.supply1_changed = n1 != ok1_ff;
      out_result_in.supply2_changed = n2 != ok2_ff;
      out_result_in.bus_good        = in_sample_ff.bus_mv > cfg_bus_ok_mv_ff;
      out_result_in.current_good    = cur_good;
      out_result_in.reset_busy      = reset_flag_in;
      out_result_in.save_request    = save;
      out_result_in.shutdown_event  = shut;
   end

   // state update as a sample completes
   always_ff @(posedge clock) begin
      if (reset) begin
         ok1_ff            <= 1'b0;
         ok2_ff            <= 1'b0;
         active_ff         <= ACT_NONE;
         drive1_ff         <= 1'b0;
         drive2_ff         <= 1'b0;
         alarm_noted_ff    <= 1'b0;
         oc_flag_ff        <= 1'b0;
         oc_start_ff       <= '0;
         switch_count_ff   <= '0;
         switch_time_ff    <= '0;
         switch_pending_ff <= 1'b0;
         reset_flag_ff     <= 1'b0;
         reset_start_ff    <= '0;
         reset_armed_ff    <= 1'b0;
      end else if (step) begin
         ok1_ff            <= out_result_in.supply1_ok;
         ok2_ff            <= out_result_in.supply2_ok;
         active_ff         <= active_in;
         drive1_ff         <= drive1_in;
         drive2_ff         <= drive2_in;
         alarm_noted_ff    <= alarm_noted_in;
         oc_flag_ff        <= oc_flag_in;
         oc_start_ff       <= oc_start_in;
         switch_count_ff   <= switch_count_in;
         switch_time_ff    <= switch_time_in;
         switch_pending_ff <= switch_pending_in;
         reset_flag_ff     <= reset_flag_in;
         reset_start_ff    <= reset_start_in;
         reset_armed_ff    <= reset_armed_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_result_ff <= out_result_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_supply1_drive   = out_result_ff.supply1_drive;
   assign rsp_supply2_drive   = out_result_ff.supply2_drive;
   assign rsp_active_supply   = out_result_ff.active_supply;
   assign rsp_supply1_ok      = out_result_ff.supply1_ok;
   assign rsp_supply2_ok      = out_result_ff.supply2_ok;
   assign rsp_supply1_changed = out_result_ff.supply1_changed;
   assign rsp_supply2_changed = out_result_ff.supply2_changed;
   assign rsp_bus_good        = out_result_ff.bus_good;
   assign rsp_current_good    = out_result_ff.current_good;
   assign rsp_reset_busy      = out_result_ff.reset_busy;
   assign rsp_save_request    = out_result_ff.save_request;
   assign rsp_shutdown_event  = out_result_ff.shutdown_event;

   // checks
   `RSF_ASSERT_IMP(a_drives_exclusive, clock, reset, 1'b1, !(drive1_ff && drive2_ff))
   `RSF_ASSERT_IMP(a_bus_reset_off, clock, reset, reset_flag_ff, !drive1_ff && !drive2_ff)
   `RSF_ASSERT_IMP(a_active_matches, clock, reset, active_ff == ACT_ONE, drive1_ff && !drive2_ff)
   `RSF_ASSERT_IMP(a_shutdown_off, clock, reset, rsp_valid && rsp_shutdown_event,
                   !rsp_supply1_drive && !rsp_supply2_drive)

endmodule

// File: verif/tb_redundant_supply_failover_top.sv
module tb_redundant_supply_failover_top
   import rsf_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [TimeW-1:0]    req_now_ms;
   logic [CodeW-1:0]    req_supply1_code;
   logic [CodeW-1:0]    req_supply2_code;
   logic [MvW-1:0]      req_bus_mv;
   logic signed [MaW-1:0] req_bus_ma;
   logic signed [MaW-1:0] req_aux_ma;
   logic                req_reset_button;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_supply1_drive;
   logic                rsp_supply2_drive;
   logic [1:0]          rsp_active_supply;
   logic                rsp_supply1_ok;
   logic                rsp_supply2_ok;
   logic                rsp_supply1_changed;
   logic                rsp_supply2_changed;
   logic                rsp_bus_good;
   logic                rsp_current_good;
   logic                rsp_reset_busy;
   logic                rsp_save_request;
   logic                rsp_shutdown_event;
   logic                csr_write_en;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   redundant_supply_failover_top dut (.*);

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Shared testbench state
   // ---------------------------------------------------------------
   result_type  status_due[$];   // expected status, oldest first
   int          mismatches = 0;
   bit          offering   = 1'b0;   // mirror of req_valid
   bit          tx_gaps_on = 1'b1;
   bit          rx_gaps_on = 1'b1;
   int          hold_req   = 0;      // long receiver hold-off, in cycles

   // stimulus scenario
   logic [31:0] sim_ms = '0;
   bit          want1 = 1'b0;
   bit          want2 = 1'b0;
   int          btn_left = 0;

   // predictor configuration
   logic [CodeW-1:0]  thr_code;
   logic [MvW-1:0]    thr_bus_mv;
   logic [MaW-1:0]    thr_cur_max;
   logic [MaW-1:0]    thr_overload;
   logic [CountW-1:0] lim_switches;
   logic [TimeW-1:0]  dur_overload;
   logic [TimeW-1:0]  dur_window;
   logic [TimeW-1:0]  dur_reset;

   // predictor state
   bit          ok1_st, ok2_st, drv1_st, drv2_st, alarm_st;
   bit          oc_flag_st, sw_pend_st, brst_flag_st, brst_armed_st;
   active_type  act_st;
   logic [31:0] oc_start_st, sw_time_st, brst_start_st;
   logic [7:0]  sw_cnt_st;

   // ---------------------------------------------------------------
   // Failover predictor
   // ---------------------------------------------------------------
   task automatic clear_model();
      thr_code     = RST_SUPPLY_OK_CODE;
      thr_bus_mv   = RST_BUS_OK_MV;
      thr_cur_max  = RST_CURRENT_MAX_MA;
      thr_overload = RST_CURRENT_OVERLOAD_MA;
      lim_switches = RST_MAX_SWITCHES;
      dur_overload = RST_OVERLOAD_TIMEOUT_MS;
      dur_window   = RST_SWITCH_WINDOW_MS;
      dur_reset    = RST_RESET_TIME_MS;
      {ok1_st, ok2_st, drv1_st, drv2_st, alarm_st} = '0;
      {oc_flag_st, sw_pend_st, brst_flag_st, brst_armed_st} = '0;
      act_st = ACT_NONE;
      oc_start_st = '0;
      sw_time_st = '0;
      brst_start_st = '0;
      sw_cnt_st = '0;
   endtask

   // modular elapsed time, strictly longer than dur
   function automatic bit time_over(logic [31:0] now, logic [31:0] start,
                                    logic [31:0] dur);
      logic [31:0] diff;
      diff = now - start;
      return diff > dur;
   endfunction

   task automatic power_to(active_type a);
      drv1_st = (a == ACT_ONE);
      drv2_st = (a == ACT_TWO);
      act_st  = a;
   endtask

   task automatic trip_off(logic [31:0] now);
      power_to(ACT_NONE);
      oc_flag_st  = 1'b1;
      oc_start_st = now;
   endtask

   task automatic note_failover(logic [31:0] now);
      if (sw_cnt_st < COUNT_MAX) sw_cnt_st++;
      sw_time_st = now;
      sw_pend_st = 1'b1;
      alarm_st   = 1'b0;
   endtask

   task automatic predict_status(input sample_type s);
      result_type r;
      bit n1, n2, ch1, ch2, save, shut, act_fail, cur_good;
      int total;
      n1 = s.supply1_code > thr_code;
      n2 = s.supply2_code > thr_code;
      ch1 = n1 != ok1_st;
      ch2 = n2 != ok2_st;
      save = 1'b0;
      shut = 1'b0;
      ok1_st = n1;
      ok2_st = n2;
      total = int'($signed(s.bus_ma)) + int'($signed(s.aux_ma));

      // end of a finished bus reset
      if (brst_flag_st && time_over(s.now_ms, brst_start_st, dur_reset)) begin
         brst_flag_st  = 1'b0;
         brst_armed_st = 1'b0;
      end

      // failover decision
      if (!brst_flag_st) begin
         act_fail = (act_st == ACT_ONE && !ok1_st) || (act_st == ACT_TWO && !ok2_st);
         if (sw_cnt_st > lim_switches && act_fail) begin
            trip_off(s.now_ms);
            shut = 1'b1;
         end else if (act_st == ACT_ONE && !ok1_st) begin
            if (ok2_st) begin
               power_to(ACT_TWO);
               note_failover(s.now_ms);
            end else if (!alarm_st) begin
               alarm_st = 1'b1;
               save = 1'b1;
            end
         end else if (act_st == ACT_TWO && !ok2_st) begin
            if (ok1_st) begin
               power_to(ACT_ONE);
               note_failover(s.now_ms);
            end else if (!alarm_st) begin
               alarm_st = 1'b1;
               save = 1'b1;
            end
         end else if (act_st == ACT_NONE) begin
            if (!oc_flag_st || time_over(s.now_ms, oc_start_st, dur_overload)) begin
               if (ok1_st) begin
                  power_to(ACT_ONE);
                  alarm_st = 1'b0;
               end else if (ok2_st) begin
                  power_to(ACT_TWO);
                  alarm_st = 1'b0;
               end else begin
                  alarm_st = 1'b1;
               end
            end
         end
      end

      cur_good = brst_flag_st || (total < int'(thr_cur_max));

      // overcurrent shutdown
      if (!brst_flag_st && total > int'(thr_overload)) begin
         trip_off(s.now_ms);
         shut = 1'b1;
      end

      // failover window expiry
      if (sw_pend_st && time_over(s.now_ms, sw_time_st, dur_window)) begin
         sw_pend_st = 1'b0;
         sw_cnt_st  = '0;
      end

      // bus reset start
      if (s.reset_button && !brst_armed_st) begin
         brst_flag_st  = 1'b1;
         brst_armed_st = 1'b1;
         brst_start_st = s.now_ms;
         power_to(ACT_NONE);
      end

      r.supply1_drive   = drv1_st;
      r.supply2_drive   = drv2_st;
      r.active_supply   = act_st;
      r.supply1_ok      = ok1_st;
      r.supply2_ok      = ok2_st;
      r.supply1_changed = ch1;
      r.supply2_changed = ch2;
      r.bus_good        = s.bus_mv > thr_bus_mv;
      r.current_good    = cur_good;
      r.reset_busy      = brst_flag_st;
      r.save_request    = save;
      r.shutdown_event  = shut;
      status_due.push_back(r);
   endtask

   // ---------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------
   task automatic report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 30) $display("mismatch: %s", msg);
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (status_due.size() == 0) begin
            report_mismatch("status transaction with none expected");
         end else begin
            want = status_due.pop_front();
            check_field("supply1_drive", rsp_supply1_drive, want.supply1_drive);
            check_field("supply2_drive", rsp_supply2_drive, want.supply2_drive);
            check_field("active_supply", rsp_active_supply, want.active_supply);
            check_field("supply1_ok", rsp_supply1_ok, want.supply1_ok);
            check_field("supply2_ok", rsp_supply2_ok, want.supply2_ok);
            check_field("supply1_changed", rsp_supply1_changed, want.supply1_changed);
            check_field("supply2_changed", rsp_supply2_changed, want.supply2_changed);
            check_field("bus_good", rsp_bus_good, want.bus_good);
            check_field("current_good", rsp_current_good, want.current_good);
            check_field("reset_busy", rsp_reset_busy, want.reset_busy);
            check_field("save_request", rsp_save_request, want.save_request);
            check_field("shutdown_event", rsp_shutdown_event, want.shutdown_event);
         end
      end
   end

   // ---------------------------------------------------------------
   // Result side stall: random bursts, plus long hold-offs on request
   // ---------------------------------------------------------------
   initial begin
      int burst;
      burst = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req != 0) begin
            burst = hold_req;
            hold_req = 0;
         end
         if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else if (rx_gaps_on && $urandom_range(7) == 0) begin
            rsp_stall <= 1'b1;
            burst = $urandom_range(16);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Sample side driving
   // ---------------------------------------------------------------
   task automatic stop_sending();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
   endtask

   // offer one sample, return at the edge that accepts it
   task automatic send_sample(input sample_type s);
      if (tx_gaps_on && $urandom_range(5) == 0) begin
         stop_sending();
         repeat ($urandom_range(17, 1)) @(posedge clock);
      end
      req_now_ms       <= s.now_ms;
      req_supply1_code <= s.supply1_code;
      req_supply2_code <= s.supply2_code;
      req_bus_mv       <= s.bus_mv;
      req_bus_ma       <= s.bus_ma;
      req_aux_ma       <= s.aux_ma;
      req_reset_button <= s.reset_button;
      if (!offering) begin
         req_valid <= 1'b1;
         offering = 1'b1;
      end
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_status(s);
   endtask

   task automatic drain_results();
      stop_sending();
      @(posedge clock);
      while (status_due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // register write; only called while the block is idle
   task automatic write_cfg(logic [CsrIdxW-1:0] idx, logic [31:0] value);
      csr_index    <= idx;
      csr_wdata    <= value;
      csr_write_en <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_SUPPLY_OK_CODE:      thr_code     = value[CodeW-1:0];
         REG_BUS_OK_MV:           thr_bus_mv   = value[MvW-1:0];
         REG_CURRENT_MAX_MA:      thr_cur_max  = value[MaW-1:0];
         REG_CURRENT_OVERLOAD_MA: thr_overload = value[MaW-1:0];
         REG_MAX_SWITCHES:        lim_switches = value[CountW-1:0];
         REG_OVERLOAD_TIMEOUT_MS: dur_overload = value;
         REG_SWITCH_WINDOW_MS:    dur_window   = value;
         REG_RESET_TIME_MS:       dur_reset    = value;
         default: ;
      endcase
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // write all registers; junk above each register width must be dropped
   task automatic set_config(logic [31:0] code, logic [31:0] bus_mv, logic [31:0] cur_max,
                             logic [31:0] overload, logic [31:0] max_sw,
                             logic [31:0] oc_to, logic [31:0] window, logic [31:0] rst_to);
      write_cfg(REG_SUPPLY_OK_CODE, code | ($urandom() << CodeW));
      write_cfg(REG_BUS_OK_MV, bus_mv | ($urandom() << MvW));
      write_cfg(REG_CURRENT_MAX_MA, cur_max | ($urandom() << MaW));
      write_cfg(REG_CURRENT_OVERLOAD_MA, overload | ($urandom() << MaW));
      write_cfg(REG_MAX_SWITCHES, max_sw | ($urandom() << CountW));
      write_cfg(REG_OVERLOAD_TIMEOUT_MS, oc_to);
      write_cfg(REG_SWITCH_WINDOW_MS, window);
      write_cfg(REG_RESET_TIME_MS, rst_to);
   endtask

   // ---------------------------------------------------------------
   // Stimulus generation
   // ---------------------------------------------------------------
   task automatic send_fields(logic [31:0] t, logic [11:0] c1, logic [11:0] c2,
                              logic [15:0] mv, int bma, int ama, bit btn);
      sample_type s;
      s.now_ms       = t;
      s.supply1_code = c1;
      s.supply2_code = c2;
      s.bus_mv       = mv;
      s.bus_ma       = 16'(bma);
      s.aux_ma       = 16'(ama);
      s.reset_button = btn;
      sim_ms = t;
      send_sample(s);
   endtask

   function automatic logic [11:0] pick_code(bit present);
      if ($urandom_range(9) == 0) return 12'($urandom_range(4095));
      if (present) begin
         if (thr_code == 12'd4095) return 12'd4095;
         if ($urandom_range(2) == 0) return thr_code + 12'd1;
         return 12'($urandom_range(4095, thr_code + 1));
      end
      if ($urandom_range(2) == 0) return thr_code;
      return 12'($urandom_range(thr_code, 0));
   endfunction

   // split a total current over the two channels
   task automatic split_current(int target, inout sample_type s);
      if (target > 65534) target = 65534;
      if (target < -65536) target = -65536;
      s.bus_ma = 16'(target / 2);
      s.aux_ma = 16'(target - target / 2);
   endtask

   task automatic next_random(output sample_type s);
      int pick;
      logic [31:0] d;
      // time step: mostly short, sometimes around a configured delay
      pick = $urandom_range(99);
      if (pick < 50) sim_ms += $urandom_range(8);
      else if (pick < 80) sim_ms += $urandom_range(40);
      else if (pick < 90) begin
         case ($urandom_range(2))
            0:       d = dur_overload;
            1:       d = dur_window;
            default: d = dur_reset;
         endcase
         sim_ms += d + $urandom_range(2);
      end else if (pick < 97) sim_ms += $urandom_range(2000);
      else sim_ms = $urandom();
      s.now_ms = sim_ms;

      if ($urandom_range(7) == 0) want1 = !want1;
      if ($urandom_range(7) == 0) want2 = !want2;
      s.supply1_code = pick_code(want1);
      s.supply2_code = pick_code(want2);

      if ($urandom_range(1) == 0) s.bus_mv = thr_bus_mv + 16'($urandom_range(2)) - 16'd1;
      else s.bus_mv = 16'($urandom_range(65535));

      pick = $urandom_range(99);
      if (pick < 45) split_current(int'($urandom_range(300)) - 100, s);
      else if (pick < 65) split_current(int'(thr_overload) + int'($urandom_range(2)) - 1, s);
      else if (pick < 80) split_current(int'(thr_cur_max) + int'($urandom_range(2)) - 1, s);
      else begin
         s.bus_ma = 16'($urandom());
         s.aux_ma = 16'($urandom());
      end

      // button presses are held for a few samples
      if (btn_left > 0) begin
         s.reset_button = 1'b1;
         btn_left--;
      end else if ($urandom_range(39) == 0) begin
         s.reset_button = 1'b1;
         btn_left = $urandom_range(5);
      end else begin
         s.reset_button = 1'b0;
      end

      // occasional pure noise
      if ($urandom_range(19) == 0) begin
         s.now_ms       = $urandom();
         s.supply1_code = 12'($urandom());
         s.supply2_code = 12'($urandom());
         s.bus_mv       = 16'($urandom());
         s.reset_button = 1'($urandom_range(1));
      end
   endtask

   task automatic run_random(int n);
      sample_type s;
      repeat (n) begin
         next_random(s);
         send_sample(s);
      end
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_directed_cases();
      // no supply at start: alarm noted silently
      send_fields(0, 0, 0, 0, -32768, -32768, 0);
      send_fields(10, 4095, 0, 65535, 0, 0, 0);
      // failover to supply two
      send_fields(20, 0, 2049, 20000, 639, 0, 0);
      // active fails with the other absent: one save request only
      send_fields(30, 2048, 2048, 20001, 640, 0, 0);
      send_fields(40, 2048, 2048, 20001, 0, 0, 0);
      send_fields(50, 4095, 4095, 0, 0, 0, 0);
      // overcurrent, then repeated overcurrent
      send_fields(60, 4095, 4095, 0, 32767, 32767, 0);
      send_fields(70, 4095, 4095, 65535, 1001, 0, 0);
      send_fields(80, 4095, 4095, 0, 500, 500, 0);
      // restart held until the timeout has strictly passed
      send_fields(5070, 4095, 4095, 20000, 0, 0, 0);
      send_fields(5071, 4095, 4095, 20001, 639, 0, 0);
      // bus reset; button during reset ignored, overcurrent masked
      send_fields(5080, 4095, 4095, 0, 0, 0, 1);
      send_fields(5090, 4095, 4095, 0, 32767, 32767, 1);
      // button held through the end: reset restarts in the same sample
      send_fields(15080, 4095, 4095, 0, 0, 0, 1);
      send_fields(15081, 4095, 4095, 0, 0, 0, 1);
      send_fields(15100, 4095, 4095, 0, 0, 0, 0);
      send_fields(25082, 4095, 0, 0, 0, 0, 0);
      // failovers past the limit inside the window
      send_fields(25090, 0, 4095, 0, 0, 0, 0);
      send_fields(25091, 4095, 0, 0, 0, 0, 0);
      send_fields(25092, 0, 4095, 0, 0, 0, 0);
      send_fields(25093, 4095, 0, 0, 0, 0, 0);
      send_fields(25094, 0, 4095, 0, 0, 0, 0);
      // time wrap
      send_fields(32'hFFFF_FFFF, 4095, 4095, 0, -1, 0, 0);
      send_fields(32'h0000_0005, 0, 0, 65535, 0, -1, 0);
   endtask

   task automatic test_random_defaults();
      run_random(250);
   endtask

   task automatic test_config_extremes();
      drain_results();
      set_config(0, 0, 0, 0, 0, 0, 0, 0);
      run_random(100);
      drain_results();
      set_config(4095, 65535, 65535, 65535, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF);
      run_random(100);
   endtask

   // alternate supplies every sample with an endless window
   task automatic test_failover_saturation();
      sample_type s;
      drain_results();
      set_config(2048, 20000, 640, 65535, 255, 0, 32'hFFFF_FFFF, 1000);
      sim_ms += 32'd100000;
      s = '0;
      for (int i = 0; i < 290; i++) begin
         if (i == 280) begin
            // count is pinned at its top; a lower limit now trips
            drain_results();
            write_cfg(REG_MAX_SWITCHES, 254);
         end
         sim_ms += 1;
         s.now_ms = sim_ms;
         s.supply1_code = i[0] ? 12'd4095 : 12'd0;
         s.supply2_code = i[0] ? 12'd0 : 12'd4095;
         s.bus_mv = 16'($urandom());
         send_sample(s);
      end
   endtask

   task automatic test_random_configs();
      int cm;
      repeat (5) begin
         drain_results();
         cm = $urandom_range(900, 100);
         set_config($urandom_range(4095), $urandom_range(65535), cm,
                    cm + $urandom_range(1200), $urandom_range(4), $urandom_range(80),
                    $urandom_range(80), $urandom_range(200));
         run_random(150);
      end
   endtask

   // receiver holds off long enough that the block backs up
   task automatic test_output_backpressure();
      tx_gaps_on = 1'b0;
      hold_req = 300;
      run_random(80);
      tx_gaps_on = 1'b1;
      drain_results();
   endtask

   task automatic test_sender_pause();
      run_random(30);
      drain_results();
      run_random(30);
      drain_results();
   endtask

   task automatic test_streaming();
      tx_gaps_on = 1'b0;
      rx_gaps_on = 1'b0;
      run_random(150);
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_now_ms       = '0;
      req_supply1_code = '0;
      req_supply2_code = '0;
      req_bus_mv       = '0;
      req_bus_ma       = '0;
      req_aux_ma       = '0;
      req_reset_button = 1'b0;
      csr_write_en     = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      clear_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_defaults();
      test_config_extremes();
      test_failover_saturation();
      test_random_configs();
      test_output_backpressure();
      test_sender_pause();
      test_streaming();

      drain_results();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && status_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // hang guard
   initial begin
      #6_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
